// ===== design/papc_pkg.sv =====
// ----------------------------------------------------------------------------
// papc_pkg
// Shared types and constants for the payload protocol classifier.
// ----------------------------------------------------------------------------
package papc_pkg;

    localparam int MAX_EXTENSIONS_DEF = 4;
    localparam int POSITION_BITS_DEF  = 16;
    localparam int HEAD_LEN           = 13;

    typedef enum logic [3:0] {
        PH_FIXED   = 4'd0,
        PH_PRE     = 4'd1,
        PH_ELEN_HI = 4'd2,
        PH_ELEN_LO = 4'd3,
        PH_TYPE_HI = 4'd4,
        PH_TYPE_LO = 4'd5,
        PH_LEN_HI  = 4'd6,
        PH_LEN_LO  = 4'd7,
        PH_SKIP    = 4'd8,
        PH_VER     = 4'd9,
        PH_DONE    = 4'd10,
        PH_DEAD    = 4'd11
    } tls_phase_t;

    localparam logic [3:0] CLS_PLAIN  = 4'd0;
    localparam logic [3:0] CLS_HTTP   = 4'd1;
    localparam logic [3:0] CLS_TLS10  = 4'd2;
    localparam logic [3:0] CLS_SSH1   = 4'd6;
    localparam logic [3:0] CLS_SSH15  = 4'd7;
    localparam logic [3:0] CLS_SSH199 = 4'd8;
    localparam logic [3:0] CLS_SSH2   = 4'd9;
    localparam logic [3:0] CLS_SSHX   = 4'd10;
    localparam logic [3:0] CLS_TELNET = 4'd11;

    localparam logic [15:0] EXT_SUPPORTED_VERSIONS = 16'd43;
    localparam logic [15:0] EXT_LEN_MAX            = 16'h1fff;
    localparam logic [15:0] TLS_VER_MIN            = 16'h0301;
    localparam logic [15:0] TLS_VER_MAX            = 16'h0304;

    typedef logic [7:0] byte_t;
    typedef byte_t [HEAD_LEN-1:0] head_t;

    // tls walk results handed to the classifier
    typedef struct packed {
        logic        hello;
        logic        found;
        logic [15:0] hello_version;
        logic [15:0] supported_version;
    } tls_info_t;

    function automatic logic is_dig(input byte_t c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ===== design/papc_tls_walk.sv =====
// ----------------------------------------------------------------------------
// papc_tls_walk
// Per-byte ServerHello walk: version, session id skip, extension scan.
// ----------------------------------------------------------------------------
module papc_tls_walk #(
    parameter int MAX_EXTENSIONS = papc_pkg::MAX_EXTENSIONS_DEF,
    parameter int POSITION_BITS  = papc_pkg::POSITION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     clear,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [7:0]               data,
    output papc_pkg::tls_info_t      info_next
);

    localparam int CNT_BITS = (MAX_EXTENSIONS > 1) ? $clog2(MAX_EXTENSIONS) : 1;

    papc_pkg::tls_phase_t phase_reg, phase_next;
    logic [15:0]          skip_reg, skip_next;
    logic [CNT_BITS-1:0]  ext_cnt_reg, ext_cnt_next;
    logic [15:0]          ext_type_reg, ext_type_next;
    logic [15:0]          ext_len_reg, ext_len_next;
    logic [15:0]          hver_reg, hver_next;
    logic [15:0]          sver_reg, sver_next;
    logic                 hello_reg, hello_next;
    logic                 found_reg, found_next;
    logic                 got1_reg, got1_next;
    logic                 got2_reg, got2_next;
    logic [15:0]          len_full;
    logic [15:0]          skip_dec;
    logic                 last_ext;

    assign len_full = {ext_len_reg[15:8], data};
    assign skip_dec = (skip_reg != 16'd0) ? skip_reg - 16'd1 : 16'd0;
    assign last_ext = ({1'b0, ext_cnt_reg} + 1'b1) >= (CNT_BITS+1)'(MAX_EXTENSIONS);

    always_comb
    begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        ext_cnt_next  = ext_cnt_reg;
        ext_type_next = ext_type_reg;
        ext_len_next  = ext_len_reg;
        hver_next     = hver_reg;
        sver_next     = sver_reg;
        hello_next    = hello_reg;
        found_next    = found_reg;
        got1_next     = got1_reg;
        got2_next     = got2_reg;
        case (phase_reg)
            papc_pkg::PH_FIXED:
            begin
                if (pos == POSITION_BITS'(9))
                    hver_next = {data, 8'h00};
                else if (pos == POSITION_BITS'(10))
                    hver_next = {hver_reg[15:8], data};
                else if (pos == POSITION_BITS'(43))
                begin
                    if (data > 8'd32)
                        phase_next = papc_pkg::PH_DEAD;
                    else
                    begin
                        skip_next  = {8'h00, data} + 16'd3;
                        phase_next = papc_pkg::PH_PRE;
                    end
                end
            end
            papc_pkg::PH_PRE:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = papc_pkg::PH_ELEN_HI;
            end
            papc_pkg::PH_ELEN_HI:
            begin
                ext_len_next = {data, 8'h00};
                phase_next   = papc_pkg::PH_ELEN_LO;
            end
            papc_pkg::PH_ELEN_LO:
            begin
                ext_len_next = len_full;
                if (len_full == 16'd0)
                    phase_next = papc_pkg::PH_DEAD;
                else
                begin
                    hello_next   = 1'b1;
                    ext_cnt_next = '0;
                    phase_next   = papc_pkg::PH_TYPE_HI;
                end
            end
            papc_pkg::PH_TYPE_HI:
            begin
                ext_type_next = {data, 8'h00};
                phase_next    = papc_pkg::PH_TYPE_LO;
            end
            papc_pkg::PH_TYPE_LO:
            begin
                ext_type_next = {ext_type_reg[15:8], data};
                phase_next    = papc_pkg::PH_LEN_HI;
            end
            papc_pkg::PH_LEN_HI:
            begin
                ext_len_next = {data, 8'h00};
                phase_next   = papc_pkg::PH_LEN_LO;
            end
            papc_pkg::PH_LEN_LO:
            begin
                ext_len_next = len_full;
                if (len_full > papc_pkg::EXT_LEN_MAX)
                    phase_next = papc_pkg::PH_DONE;
                else if (ext_type_reg == papc_pkg::EXT_SUPPORTED_VERSIONS)
                begin
                    skip_next  = (len_full < 16'd2) ? 16'd2 : len_full;
                    sver_next  = 16'd0;
                    phase_next = papc_pkg::PH_VER;
                end
                else if (len_full == 16'd0)
                begin
                    if (last_ext)
                        phase_next = papc_pkg::PH_DONE;
                    else
                    begin
                        ext_cnt_next = ext_cnt_reg + 1'b1;
                        phase_next   = papc_pkg::PH_TYPE_HI;
                    end
                end
                else
                begin
                    skip_next  = len_full;
                    phase_next = papc_pkg::PH_SKIP;
                end
            end
            papc_pkg::PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (last_ext)
                        phase_next = papc_pkg::PH_DONE;
                    else
                    begin
                        ext_cnt_next = ext_cnt_reg + 1'b1;
                        phase_next   = papc_pkg::PH_TYPE_HI;
                    end
                end
            end
            papc_pkg::PH_VER:
            begin
                if (!got1_reg)
                begin
                    sver_next = {data, 8'h00};
                    got1_next = 1'b1;
                end
                else if (!got2_reg)
                begin
                    sver_next = {sver_reg[15:8], data};
                    got2_next = 1'b1;
                end
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    found_next = 1'b1;
                    phase_next = papc_pkg::PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign info_next = '{hello: hello_next, found: found_next,
                         hello_version: hver_next, supported_version: sver_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= papc_pkg::PH_FIXED;
            skip_reg     <= '0;
            ext_cnt_reg  <= '0;
            ext_type_reg <= '0;
            ext_len_reg  <= '0;
            hver_reg     <= '0;
            sver_reg     <= '0;
            hello_reg    <= 1'b0;
            found_reg    <= 1'b0;
            got1_reg     <= 1'b0;
            got2_reg     <= 1'b0;
        end
        else if (clear)
        begin
            phase_reg    <= papc_pkg::PH_FIXED;
            skip_reg     <= '0;
            ext_cnt_reg  <= '0;
            ext_type_reg <= '0;
            ext_len_reg  <= '0;
            hver_reg     <= '0;
            sver_reg     <= '0;
            hello_reg    <= 1'b0;
            found_reg    <= 1'b0;
            got1_reg     <= 1'b0;
            got2_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            skip_reg     <= skip_next;
            ext_cnt_reg  <= ext_cnt_next;
            ext_type_reg <= ext_type_next;
            ext_len_reg  <= ext_len_next;
            hver_reg     <= hver_next;
            sver_reg     <= sver_next;
            hello_reg    <= hello_next;
            found_reg    <= found_next;
            got1_reg     <= got1_next;
            got2_reg     <= got2_next;
        end
    end

    // the version bytes are only collected inside supported_versions
    assert property (@(posedge clk) disable iff (!rst_n)
        got2_reg |-> got1_reg)
        else $error("second version byte without first");
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (phase_reg == papc_pkg::PH_DONE))
        else $error("version found outside done phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> hello_reg)
        else $error("version found before hello complete");

endmodule

// ===== design/papc_classify.sv =====
// ----------------------------------------------------------------------------
// papc_classify
// Combinational class decision from the head bytes, count and tls walk.
// ----------------------------------------------------------------------------
module papc_classify #(
    parameter int POSITION_BITS = papc_pkg::POSITION_BITS_DEF
) (
    input  papc_pkg::head_t          head,
    input  logic [POSITION_BITS-1:0] count,
    input  papc_pkg::tls_info_t      info,
    output logic [3:0]               app_class
);

    papc_pkg::head_t h;
    logic            http_status;
    logic            http_method;
    logic            http_ok;
    logic            tls_base;
    logic [15:0]     ver;
    logic            tls_ok;
    logic            telnet_ok;
    logic            ssh_ok;
    logic            ssh_fmt;
    logic [3:0]      ssh_cls;
    logic [15:0]     ver_off;

    assign h = head;

    assign http_status = (count >= POSITION_BITS'(13)) &&
        h[0] == "H" && h[1] == "T" && h[2] == "T" && h[3] == "P" && h[4] == "/" &&
        papc_pkg::is_dig(h[5]) && h[6] == "." && papc_pkg::is_dig(h[7]) &&
        h[8] == " " && papc_pkg::is_dig(h[9]) && papc_pkg::is_dig(h[10]) &&
        papc_pkg::is_dig(h[11]) && h[12] == " ";

    assign http_method = (count >= POSITION_BITS'(8)) && (
        (h[0] == "G" && h[1] == "E" && h[2] == "T" && h[3] == " ") ||
        (h[0] == "P" && h[1] == "O" && h[2] == "S" && h[3] == "T" && h[4] == " ") ||
        (h[0] == "P" && h[1] == "U" && h[2] == "T" && h[3] == " ") ||
        (h[0] == "P" && h[1] == "A" && h[2] == "T" && h[3] == "C" && h[4] == "H" &&
         h[5] == " ") ||
        (h[0] == "H" && h[1] == "E" && h[2] == "A" && h[3] == "D" && h[4] == " ") ||
        (h[0] == "D" && h[1] == "E" && h[2] == "L" && h[3] == "E" && h[4] == "T" &&
         h[5] == "E" && h[6] == " ") ||
        (h[0] == "O" && h[1] == "P" && h[2] == "T" && h[3] == "I" && h[4] == "O" &&
         h[5] == "N" && h[6] == "S" && h[7] == " ") ||
        (h[0] == "C" && h[1] == "O" && h[2] == "N" && h[3] == "N" && h[4] == "E" &&
         h[5] == "C" && h[6] == "T" && h[7] == " ") ||
        (h[0] == "T" && h[1] == "R" && h[2] == "A" && h[3] == "C" && h[4] == "E" &&
         h[5] == " "));

    assign http_ok = http_status || http_method;

    assign tls_base = info.hello && h[0] == 8'd22 && h[1] == 8'd3 &&
        h[2] >= 8'd1 && h[2] <= 8'd4 && h[5] == 8'd2;
    assign ver = (info.found && info.supported_version != 16'd0 &&
                  info.supported_version > info.hello_version) ?
                 info.supported_version : info.hello_version;
    assign tls_ok  = tls_base && ver >= papc_pkg::TLS_VER_MIN &&
                     ver <= papc_pkg::TLS_VER_MAX;
    assign ver_off = ver - papc_pkg::TLS_VER_MIN;

    assign telnet_ok = (count >= POSITION_BITS'(3)) && h[0] == 8'hff &&
        h[1] >= 8'hf0 && h[1] < 8'hff && (h[2] <= 8'd35 || h[2] == 8'hff);

    assign ssh_ok  = (count >= POSITION_BITS'(8)) && h[0] == 8'h53 && h[1] == 8'h53 &&
                     h[2] == 8'h48 && h[3] == 8'h2d;
    assign ssh_fmt = papc_pkg::is_dig(h[4]) && h[5] == "." && papc_pkg::is_dig(h[6]) &&
                     (papc_pkg::is_dig(h[7]) || h[7] == "-");

    always_comb
    begin
        ssh_cls = papc_pkg::CLS_SSHX;
        if (ssh_fmt)
        begin
            if (h[4] == "1" && h[6] == "0")
                ssh_cls = papc_pkg::CLS_SSH1;
            else if (h[4] == "1" && h[6] == "5")
                ssh_cls = papc_pkg::CLS_SSH15;
            else if (h[4] == "1" && h[6] == "9")
                ssh_cls = papc_pkg::CLS_SSH199;
            else if (h[4] == "2" && h[6] == "0")
                ssh_cls = papc_pkg::CLS_SSH2;
        end
    end

    always_comb
    begin
        if (http_ok)
            app_class = papc_pkg::CLS_HTTP;
        else if (tls_ok)
            app_class = papc_pkg::CLS_TLS10 + ver_off[3:0];
        else if (telnet_ok)
            app_class = papc_pkg::CLS_TELNET;
        else if (ssh_ok)
            app_class = ssh_cls;
        else
            app_class = papc_pkg::CLS_PLAIN;
    end

endmodule

// ===== design/payload_app_protocol_classifier.sv =====
// ----------------------------------------------------------------------------
// payload_app_protocol_classifier
// Classifies a tcp payload streamed one byte per transfer.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries payload_byte, last_byte
// and empty_payload. A transfer with last_byte or empty_payload set produces
// one app_class transfer on the output channel (out_valid/out_stall); other
// transfers produce none. Each byte is registered at the input, walked and
// classified from that register, and the class is held in an output
// register that drives out_valid. Throughput is one byte per cycle while
// in_stall is low; the input register and the output register together
// act as a two-deep stage, so bytes keep flowing while a result waits.
// When the receiver stalls with a result pending, the input stage fills
// and in_stall rises only when a second result would collide.
// Reset clears the byte counter, the tls walk and both valid flags; the head
// byte store is not cleared and is only read at positions already written.
// ----------------------------------------------------------------------------
module payload_app_protocol_classifier #(
    parameter int MAX_EXTENSIONS = papc_pkg::MAX_EXTENSIONS_DEF,
    parameter int POSITION_BITS  = papc_pkg::POSITION_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] payload_byte,
    input  logic       last_byte,
    input  logic       empty_payload,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] app_class
);

    localparam int HEAD_IDX = $clog2(papc_pkg::HEAD_LEN);

    logic                     s_valid_reg;
    logic [7:0]               s_byte_reg;
    logic                     s_last_reg;
    logic                     s_empty_reg;
    logic                     o_valid_reg;
    logic [3:0]               o_class_reg;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    papc_pkg::head_t          head_reg, head_next;
    papc_pkg::tls_info_t      info_next;
    logic [3:0]               class_next;
    logic                     s_emits;
    logic                     s_go;
    logic                     o_free;
    logic                     in_take;

    assign s_emits  = s_last_reg || s_empty_reg;
    assign o_free   = !o_valid_reg || !out_stall;
    // staged transfer advances unless it carries a result that cannot leave
    assign s_go     = s_valid_reg && (!s_emits || o_free);
    assign in_stall = s_valid_reg && !s_go;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        head_next = head_reg;
        if (pos_reg < POSITION_BITS'(papc_pkg::HEAD_LEN))
            head_next[pos_reg[HEAD_IDX-1:0]] = s_byte_reg;
        pos_next = (pos_reg != {POSITION_BITS{1'b1}}) ? pos_reg + 1'b1 : pos_reg;
    end

    papc_tls_walk #(
        .MAX_EXTENSIONS (MAX_EXTENSIONS),
        .POSITION_BITS  (POSITION_BITS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s_go && !s_empty_reg),
        .clear     (s_go && s_emits),
        .pos       (pos_reg),
        .data      (s_byte_reg),
        .info_next (info_next)
    );

    papc_classify #(
        .POSITION_BITS (POSITION_BITS)
    ) u_cls (
        .head      (head_next),
        .count     (pos_next),
        .info      (info_next),
        .app_class (class_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            if (in_take)
                s_valid_reg <= 1'b1;
            else if (s_go)
                s_valid_reg <= 1'b0;
            if (s_go && s_emits)
                o_valid_reg <= 1'b1;
            else if (!out_stall)
                o_valid_reg <= 1'b0;
            if (s_go)
                pos_reg <= s_emits ? '0 : pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s_byte_reg  <= payload_byte;
            s_last_reg  <= last_byte;
            s_empty_reg <= empty_payload;
        end
        if (s_go && !s_empty_reg)
            head_reg <= head_next;
        if (s_go && s_emits)
            o_class_reg <= s_empty_reg ? papc_pkg::CLS_PLAIN : class_next;
    end

    assign out_valid = o_valid_reg;
    assign app_class = o_class_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && out_stall) |=> (o_valid_reg && $stable(o_class_reg)))
        else $error("pending result lost under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s_valid_reg && s_emits && o_valid_reg))
        else $error("input stalled without a blocked result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_go && s_emits) |=> (pos_reg == '0))
        else $error("byte count not cleared after result");
    assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (o_class_reg <= papc_pkg::CLS_TELNET))
        else $error("class code out of range");

endmodule
